// File: rtl/core/i2a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

    // opcodes carried on tuser
    localparam logic [1:0] OP_HEX  = 2'd0;
    localparam logic [1:0] OP_UDEC = 2'd1;
    localparam logic [1:0] OP_SDEC = 2'd2;

    localparam int DEF_MAX_FIELD_WIDTH = 31;

    // ten BCD digits cover any 32-bit magnitude
    localparam int NUM_DEC_DIGITS = 10;
    localparam int NUM_HEX_DIGITS = 8;
    localparam int BCD_W          = 4 * NUM_DEC_DIGITS;
    localparam int VALUE_W        = 32;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_A_LC  = 8'h61;
    localparam logic [7:0] ASCII_F_LC  = 8'h66;
    localparam logic [7:0] ASCII_HEX_BASE = ASCII_A_LC - 8'd10;

    // add-3 on every digit of five or more, ahead of the shift
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int k = 0; k < NUM_DEC_DIGITS; k++) begin
            if (b[4*k +: 4] >= 4'd5) begin
                r[4*k +: 4] = b[4*k +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return ASCII_ZERO + {4'd0, nib};
        end
        return ASCII_HEX_BASE + {4'd0, nib};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/int_to_ascii_formatter.sv
`timescale 1ns / 1ps
`default_nettype none

// Integer to ASCII formatter.
// Input stream: one beat per number. s_axis_tuser[1:0] is the opcode
// (hex lower case, unsigned decimal, signed decimal; the spare code acts
// as unsigned decimal). s_axis_tdata holds value, field width and zero fill.
// Output stream: one beat per character, tlast on the final digit, and on
// that beat tdata[12:8] carries padding plus digits (minus excluded).
// Flow per number: decimal values go through a bit-serial double-dabble
// converter, one bit per cycle; hex values skip it. An align pass then
// shifts leading zero digits out, one digit per cycle, which also yields
// the digit count. Characters then leave at one per cycle while the
// receiver is ready: minus, padding, digits.
// One number is in flight at a time; s_axis_tready is high only in idle.
// A stalled receiver simply holds the output register and the emit
// sequence waits; nothing is dropped.
// Reset (synchronous, active low) returns to idle with the output empty.
module int_to_ascii_formatter
    import i2a_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = DEF_MAX_FIELD_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // value[31:0], field_width[36:32], zero_fill[37]
    input  wire logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // character[7:0], char_count[12:8]
    output logic             m_axis_tlast
);

    localparam int PAD_W = $clog2(MAX_FIELD_WIDTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_ALIGN = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_DIGS  = 3'd5;

    logic [2:0]         r_state;
    logic [VALUE_W-1:0] r_bin;       // binary shifted out MSB first
    logic [BCD_W-1:0]   r_bcd;       // digit shift register, MSD at top
    logic [4:0]         r_bitcnt;
    logic [3:0]         r_ndig;      // digits left in the window
    logic [PAD_W-1:0]   r_width;
    logic [PAD_W-1:0]   r_pad;
    logic [4:0]         r_total;
    logic               r_zfill;
    logic               r_neg;

    logic               r_ovalid;
    logic [7:0]         r_char;
    logic               r_last;
    logic [4:0]         r_cnt;

    logic               s_in_acc;
    logic               s_slot;
    logic               s_emit;
    logic [VALUE_W-1:0] s_in_value;
    logic [4:0]         s_in_width;
    logic [1:0]         s_in_op;
    logic               s_in_neg;
    logic [3:0]         s_top;
    logic [BCD_W-1:0]   s_bcd_adj;
    logic [6:0]         s_w_ext;
    logic [6:0]         s_d_ext;
    logic [6:0]         s_total;

    assign s_in_value = s_axis_tdata[31:0];
    assign s_in_width = s_axis_tdata[36:32];
    assign s_in_op    = s_axis_tuser;
    assign s_in_neg   = (s_in_op == OP_SDEC) && s_in_value[VALUE_W-1];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_slot        = !r_ovalid || m_axis_tready;   // output register free this cycle
    // a character is loaded this cycle
    assign s_emit        = s_slot && ((r_state == ST_SIGN) || (r_state == ST_PAD)
                                      || (r_state == ST_DIGS));
    assign s_top         = r_bcd[BCD_W-1 -: 4];
    assign s_bcd_adj     = bcd_adjust(r_bcd);

    assign s_w_ext = 7'(r_width);
    assign s_d_ext = 7'(r_ndig);
    assign s_total = (s_w_ext > s_d_ext) ? s_w_ext : s_d_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (s_emit) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_in_acc) begin
                        r_zfill <= s_axis_tdata[37];
                        r_neg   <= s_in_neg;
                        if (int'(s_in_width) > MAX_FIELD_WIDTH) begin
                            r_width <= PAD_W'(MAX_FIELD_WIDTH);
                        end else begin
                            r_width <= PAD_W'(s_in_width);
                        end
                        if (s_in_op == OP_HEX) begin
                            r_bcd   <= {s_in_value, 8'd0};
                            r_ndig  <= 4'(NUM_HEX_DIGITS);
                            r_state <= ST_ALIGN;
                        end else begin
                            r_bin    <= s_in_neg ? (VALUE_W'(0) - s_in_value) : s_in_value;
                            r_bcd    <= '0;
                            r_bitcnt <= '0;
                            r_state  <= ST_CONV;
                        end
                    end
                end

                ST_CONV: begin
                    // double dabble: one binary bit enters per cycle
                    r_bcd    <= {s_bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                    r_bin    <= {r_bin[VALUE_W-2:0], 1'b0};
                    r_bitcnt <= r_bitcnt + 5'd1;
                    if (r_bitcnt == 5'(VALUE_W - 1)) begin
                        r_ndig  <= 4'(NUM_DEC_DIGITS);
                        r_state <= ST_ALIGN;
                    end
                end

                ST_ALIGN: begin
                    // drop leading zero digits, keep at least one
                    if (s_top == 4'd0 && r_ndig > 4'd1) begin
                        r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_ndig <= r_ndig - 4'd1;
                    end else begin
                        r_pad   <= (s_w_ext > s_d_ext) ? PAD_W'(s_w_ext - s_d_ext) : '0;
                        r_total <= s_total[4:0];
                        if (r_neg) begin
                            r_state <= ST_SIGN;
                        end else if (s_w_ext > s_d_ext) begin
                            r_state <= ST_PAD;
                        end else begin
                            r_state <= ST_DIGS;
                        end
                    end
                end

                ST_SIGN: begin
                    if (s_slot) begin
                        r_char   <= ASCII_MINUS;
                        r_last   <= 1'b0;
                        r_cnt    <= '0;
                        r_state  <= (r_pad != '0) ? ST_PAD : ST_DIGS;
                    end
                end

                ST_PAD: begin
                    if (s_slot) begin
                        r_char   <= r_zfill ? ASCII_ZERO : ASCII_SPACE;
                        r_last   <= 1'b0;
                        r_cnt    <= '0;
                        r_pad    <= r_pad - PAD_W'(1);
                        if (r_pad == PAD_W'(1)) begin
                            r_state <= ST_DIGS;
                        end
                    end
                end

                ST_DIGS: begin
                    if (s_slot) begin
                        r_char   <= nib_to_ascii(s_top);
                        r_bcd    <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_ndig   <= r_ndig - 4'd1;
                        if (r_ndig == 4'd1) begin
                            r_last  <= 1'b1;
                            r_cnt   <= r_total;
                            r_state <= ST_IDLE;
                        end else begin
                            r_last <= 1'b0;
                            r_cnt  <= '0;
                        end
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'd0, r_cnt, r_char};
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire

// File: rtl/core/i2a_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module i2a_checker
    import i2a_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // one number at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a number is in flight");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // count only on the last beat
    a_count_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[12:8] == 5'd0)
        else $error("count on a beat that is not last");

    // the final character is always a digit
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tdata[7:0] >= ASCII_ZERO && m_axis_tdata[7:0] <= ASCII_NINE) ||
            (m_axis_tdata[7:0] >= ASCII_A_LC && m_axis_tdata[7:0] <= ASCII_F_LC))
        else $error("last character is not a digit");

endmodule

bind int_to_ascii_formatter i2a_checker u_i2a_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import i2a_pkg::*;

    // one number as offered on the input stream
    typedef struct {
        logic [1:0]  op;
        logic [31:0] value;
        logic [4:0]  width;
        logic        zfill;
    } t_number;

    // one character beat as it should leave the block
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic [4:0] cnt;
    } t_char_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // value[31:0], field_width[36:32], zero_fill[37]
    logic [1:0]  s_axis_tuser = '0;   // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // character[7:0], char_count[12:8]
    logic        m_axis_tlast;

    t_number     number_q[$];
    t_char_beat  pending_chars[$];
    int          total_numbers;
    int          accepted_cnt = 0;
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    logic        hold_off = 1'b0;
    t_number     cur;
    t_char_beat  want;

    int_to_ascii_formatter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Expected characters of one number, appended in emission order:
    // minus (signed and negative), then padding, then digits.
    function automatic void format_number(input logic [1:0] op, input logic [31:0] val,
                                          input logic [4:0] fw, input logic zf);
        logic [7:0] digs[$];
        logic [31:0] mag;
        logic [3:0] nib;
        logic [7:0] padch;
        logic started;
        int w;
        int pad;
        int total;
        w = fw;
        if (w > DEF_MAX_FIELD_WIDTH) begin
            w = DEF_MAX_FIELD_WIDTH;
        end
        padch = zf ? ASCII_ZERO : ASCII_SPACE;
        mag = val;
        if (op == OP_HEX) begin
            started = 1'b0;
            for (int k = 7; k >= 0; k--) begin
                nib = val[4*k +: 4];
                // leading zero nibbles dropped, but the lowest always prints
                if (nib != 4'd0 || started || k == 0) begin
                    started = 1'b1;
                    digs.push_back(nib < 4'd10 ? ASCII_ZERO + 8'(nib)
                                               : ASCII_A_LC - 8'd10 + 8'(nib));
                end
            end
        end else begin
            // spare opcode falls through to unsigned decimal
            if (op == OP_SDEC && val[31]) begin
                pending_chars.push_back('{ch: ASCII_MINUS, last: 1'b0, cnt: 5'd0});
                mag = 32'd0 - val;   // most negative stays 0x80000000
            end
            do begin
                digs.push_front(ASCII_ZERO + 8'(mag % 32'd10));
                mag = mag / 32'd10;
            end while (mag != 32'd0);
        end
        pad = (w > digs.size()) ? w - digs.size() : 0;
        total = pad + digs.size();
        for (int k = 0; k < pad; k++) begin
            pending_chars.push_back('{ch: padch, last: 1'b0, cnt: 5'd0});
        end
        for (int k = 0; k < digs.size(); k++) begin
            if (k == digs.size() - 1) begin
                pending_chars.push_back('{ch: digs[k], last: 1'b1, cnt: 5'(total)});
            end else begin
                pending_chars.push_back('{ch: digs[k], last: 1'b0, cnt: 5'd0});
            end
        end
    endfunction

    // Idle length: mostly none or short, now and then long; quiet stretches,
    // one window in every four, with no idling at all.
    function automatic int pick_gap();
        int r;
        if ((cycle_cnt / 512) % 4 == 1) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        case ($urandom_range(0, 6))
            0, 1: begin
                v = $urandom;
            end
            2: begin
                // spread the digit count
                v = $urandom >> $urandom_range(0, 31);
            end
            3: begin
                v = $urandom_range(0, 20);
            end
            4: begin
                v = 32'd0 - 32'($urandom_range(1, 20));
            end
            5: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h8000_0001;
                endcase
            end
            default: begin
                v = $urandom_range(0, 1) ? 32'd1_000_000_000 : 32'd999_999_999;
            end
        endcase
        return v;
    endfunction

    function automatic void add_number(input logic [1:0] op, input logic [31:0] val,
                                       input logic [4:0] fw, input logic zf);
        number_q.push_back('{op: op, value: val, width: fw, zfill: zf});
    endfunction

    // Sender: offers the next number once the slot is free, after its gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end else if (number_q.size() > 0) begin
                cur = number_q.pop_front();
                s_axis_tdata  <= {2'b00, cur.zfill, cur.width, cur.value};
                s_axis_tuser  <= cur.op;
                s_axis_tvalid <= 1'b1;
                send_gap      <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus the long hold-off while hold_off is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
        end else if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            m_axis_tready <= 1'b0;
            recv_stall    <= recv_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
            recv_stall    <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    // Monitor: check each output beat against the oldest expectation, then
    // predict from any input beat taken at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_chars.size() == 0) begin
                    $error("unexpected output beat: character %h last %b count %0d",
                           m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[12:8]);
                    fail_cnt++;
                end else begin
                    want = pending_chars.pop_front();
                    if (m_axis_tdata[7:0] !== want.ch) begin
                        $error("character: expected %h, got %h", want.ch, m_axis_tdata[7:0]);
                        fail_cnt++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %b, got %b", want.last, m_axis_tlast);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[12:8] !== want.cnt) begin
                        $error("char_count: expected %0d, got %0d", want.cnt,
                               m_axis_tdata[12:8]);
                        fail_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                format_number(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[36:32],
                              s_axis_tdata[37]);
                accepted_cnt <= accepted_cnt + 1;
            end
        end
    end

    // Long receiver hold-off, so the sender backs up against s_axis_tready.
    initial begin
        wait (accepted_cnt >= 40);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #20_000_000;
        $display("int_to_ascii_formatter regression: fail");
        $finish;
    end

    initial begin
        // directed: extremes of every field and every opcode
        add_number(OP_HEX,  32'h0000_0000, 5'd0,  1'b0);
        add_number(OP_HEX,  32'hFFFF_FFFF, 5'd0,  1'b0);
        add_number(OP_HEX,  32'h89AB_CDEF, 5'd31, 1'b1);
        add_number(OP_HEX,  32'h0123_4567, 5'd31, 1'b0);
        add_number(OP_HEX,  32'h0000_001A, 5'd8,  1'b1);
        add_number(OP_UDEC, 32'h0000_0000, 5'd0,  1'b1);
        add_number(OP_UDEC, 32'hFFFF_FFFF, 5'd0,  1'b0);
        add_number(OP_UDEC, 32'hFFFF_FFFF, 5'd31, 1'b1);
        add_number(OP_UDEC, 32'd12345,     5'd3,  1'b1);   // width under digit count
        add_number(OP_UDEC, 32'd7,         5'd5,  1'b0);
        add_number(OP_SDEC, 32'h8000_0000, 5'd0,  1'b0);   // most negative
        add_number(OP_SDEC, 32'h8000_0000, 5'd31, 1'b0);   // largest beat count
        add_number(OP_SDEC, 32'hFFFF_FFFF, 5'd4,  1'b1);
        add_number(OP_SDEC, 32'hFFFF_FFFF, 5'd4,  1'b0);
        add_number(OP_SDEC, 32'h7FFF_FFFF, 5'd0,  1'b0);
        add_number(OP_SDEC, 32'd42,        5'd1,  1'b1);
        add_number(OP_SDEC, 32'd0,         5'd31, 1'b1);
        add_number(2'd3,    32'd100,       5'd6,  1'b0);   // spare opcode
        add_number(2'd3,    32'hFFFF_FFFF, 5'd12, 1'b1);
        add_number(2'd3,    32'h8000_0000, 5'd0,  1'b0);
        for (int n = 0; n < 420; n++) begin
            add_number(2'($urandom_range(0, 3)), rand_value(),
                       ($urandom_range(0, 99) < 15) ? 5'd0 : 5'($urandom_range(0, 31)),
                       1'($urandom_range(0, 1)));
        end
        total_numbers = number_q.size();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (accepted_cnt == total_numbers);
        wait (pending_chars.size() == 0);
        // let any stray beats show up
        repeat (120) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("int_to_ascii_formatter regression: pass");
        end else begin
            $display("int_to_ascii_formatter regression: fail");
        end
        $finish;
    end

endmodule
